[rtl/sct_pkg.sv]
`timescale 1ns / 1ps
// sct_pkg: shared types and constants for the sphere contact test.
// No dependencies.
package sct_pkg;

  localparam int unsigned SCT_QDEPTH = 4;
  localparam logic [15:0] SCT_EPS_RESET = 16'd7;
  localparam logic [16:0] SCT_ONE_Q16 = 17'd65536;
  localparam int unsigned SCT_SQ_STAGES = 32;
  localparam int unsigned SCT_DIV_STAGES = 17;

  // Register select values (word index in paddr[2]).
  localparam logic SCT_REG_EPS = 1'b0;

  // Classified item handed from front to back.
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        limit;
  } sct_item_t;

endpackage

[rtl/sct_front.sv]
`timescale 1ns / 1ps
// sct_front: accepts a shape pair, clamps for box mode, forms the difference
// vector and radius limit. Depends on sct_pkg.
module sct_front import sct_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          mode,
  input  logic [95:0]   a_pos,
  input  logic [95:0]   b_pos,
  input  logic [95:0]   c_pos,
  input  logic [30:0]   radius_a,
  input  logic [30:0]   radius_c,
  output logic          item_valid,
  input  logic          item_ready,
  output sct_item_t     item
);

  logic      fr_v_r;
  sct_item_t fr_item_r;
  sct_item_t item_nxt;
  logic signed [32:0] d_nxt [3];

  always_comb begin
    logic signed [31:0] av, bv, cv, t, base;
    for (int i = 0; i < 3; i++) begin
      av = a_pos[32*i +: 32];
      bv = b_pos[32*i +: 32];
      cv = c_pos[32*i +: 32];
      t = (cv < bv) ? cv : bv;
      base = (av > t) ? av : t;
      if (!mode) base = av;
      d_nxt[i] = 33'(cv) - 33'(base);
    end
  end

  always_comb begin
    item_nxt.dx = d_nxt[0];
    item_nxt.dy = d_nxt[1];
    item_nxt.dz = d_nxt[2];
    item_nxt.limit = mode ? {1'b0, radius_c} : ({1'b0, radius_a} + {1'b0, radius_c});
  end

  assign in_ready   = !fr_v_r || item_ready;
  assign item_valid = fr_v_r;
  assign item       = fr_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (in_ready) begin
      fr_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

[rtl/sct_fifo.sv]
`timescale 1ns / 1ps
// sct_fifo: short queue of classified items between front and back.
// Depends on sct_pkg.
module sct_fifo import sct_pkg::*; #(
  parameter int unsigned QDEPTH = SCT_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  sct_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output sct_item_t rd_item
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  sct_item_t      mem_r [QDEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           push, pop;

  assign wr_ready = (cnt_r != CW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop)  rp_r <= inc(rp_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule

[rtl/sct_back.sv]
`timescale 1ns / 1ps
// sct_back: pipelined squares, limit test, bit-per-stage square root and
// three bit-per-stage normal dividers, ending in the output register. Uses sct_pkg.
module sct_back import sct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] eps,
  input  logic        item_valid,
  output logic        item_ready,
  input  sct_item_t   item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [17:0] normal_x,
  output logic [17:0] normal_y,
  output logic [17:0] normal_z,
  output logic [31:0] depth
);

  localparam int unsigned SQ = SCT_SQ_STAGES;
  localparam int unsigned DV = SCT_DIV_STAGES;
  localparam int unsigned NST = 3 + (SQ + 1) + (DV + 1) + 1;

  typedef struct packed {
    logic             hit;
    logic [2:0][31:0] m;
    logic [2:0]       sg;
    logic [31:0]      lim;
  } sq_ctl_t;

  typedef struct packed {
    logic        hit;
    logic        dflt;
    logic [2:0]  sg;
    logic [31:0] len;
    logic [31:0] depth;
  } dv_ctl_t;

  logic [NST-1:0] vld_r;
  logic           en;

  assign en         = !vld_r[NST-1] || out_ready;
  assign item_ready = en;
  assign out_valid  = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], item_valid};
    end
  end

  // stage A: magnitudes
  logic [2:0][31:0] ma_r;
  logic [2:0]       sga_r;
  logic [31:0]      lima_r;
  logic [2:0][32:0] dvec;
  assign dvec = {item.dz, item.dy, item.dx};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sga_r[i] <= dvec[i][32];
        ma_r[i]  <= dvec[i][32] ? 32'(-dvec[i]) : dvec[i][31:0];
      end
      lima_r <= item.limit;
    end
  end

  // stage B: squares
  logic [2:0][63:0] sqb_r;
  logic [63:0]      lim2b_r;
  logic [2:0][31:0] mb_r;
  logic [2:0]       sgb_r;
  logic [31:0]      limb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sqb_r[i] <= 64'(ma_r[i]) * 64'(ma_r[i]);
      lim2b_r <= 64'(lima_r) * 64'(lima_r);
      mb_r    <= ma_r;
      sgb_r   <= sga_r;
      limb_r  <= lima_r;
    end
  end

  // stage C: sum of squares
  logic [65:0]      sumc_r;
  logic [63:0]      lim2c_r;
  logic [2:0][31:0] mc_r;
  logic [2:0]       sgc_r;
  logic [31:0]      limc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sumc_r  <= 66'(sqb_r[0]) + 66'(sqb_r[1]) + 66'(sqb_r[2]);
      lim2c_r <= lim2b_r;
      mc_r    <= mb_r;
      sgc_r   <= sgb_r;
      limc_r  <= limb_r;
    end
  end

  // square root: index 0 holds the radicand and the limit test
  logic [63:0] sq_rem_r [SQ+1];
  logic [31:0] sq_res_r [SQ+1];
  sq_ctl_t     sq_ctl_r [SQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]     <= sumc_r[63:0];
      sq_res_r[0]     <= '0;
      sq_ctl_r[0].hit <= (sumc_r < {2'b00, lim2c_r});
      sq_ctl_r[0].m   <= mc_r;
      sq_ctl_r[0].sg  <= sgc_r;
      sq_ctl_r[0].lim <= limc_r;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sq
    localparam int K = SQ - 1 - j;
    logic [65:0] t;
    logic        ge;
    // trial (res + 2^K)^2 - res^2
    assign t  = ({34'd0, sq_res_r[j]} << (K + 1)) + (66'd1 << (2 * K));
    assign ge = ({2'b00, sq_rem_r[j]} >= t);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[j+1] <= ge ? (sq_rem_r[j] - t[63:0]) : sq_rem_r[j];
        sq_res_r[j+1] <= ge ? (sq_res_r[j] | (32'd1 << K)) : sq_res_r[j];
        sq_ctl_r[j+1] <= sq_ctl_r[j];
      end
    end
  end

  // divide prep: index 0 holds numerators, depth and default-normal flag
  logic [2:0][48:0] dv_rem_r [DV+1];
  logic [2:0][16:0] dv_q_r   [DV+1];
  dv_ctl_t          dv_ctl_r [DV+1];
  logic [31:0]      len;
  assign len = sq_res_r[SQ];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= {1'b0, sq_ctl_r[SQ].m[i], 16'd0} + 49'(len >> 1);
      end
      dv_q_r[0]         <= '0;
      dv_ctl_r[0].hit   <= sq_ctl_r[SQ].hit;
      dv_ctl_r[0].dflt  <= (len <= {16'd0, eps});
      dv_ctl_r[0].sg    <= sq_ctl_r[SQ].sg;
      dv_ctl_r[0].len   <= len;
      dv_ctl_r[0].depth <= sq_ctl_r[SQ].lim - len;
    end
  end

  for (genvar j = 0; j < DV; j++) begin : g_dv
    localparam int K = DV - 1 - j;
    logic [48:0] dt;
    assign dt = {17'd0, dv_ctl_r[j].len} << K;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem_r[j][i] >= dt) begin
            dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dt;
            dv_q_r[j+1][i]   <= dv_q_r[j][i] | (17'd1 << K);
          end else begin
            dv_rem_r[j+1][i] <= dv_rem_r[j][i];
            dv_q_r[j+1][i]   <= dv_q_r[j][i];
          end
        end
        dv_ctl_r[j+1] <= dv_ctl_r[j];
      end
    end
  end

  // output register
  dv_ctl_t          fc;
  logic [2:0][17:0] nrm;
  assign fc = dv_ctl_r[DV];

  always_comb begin
    logic [16:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (dv_q_r[DV][i] > SCT_ONE_Q16) ? SCT_ONE_Q16 : dv_q_r[DV][i];
      nrm[i] = fc.sg[i] ? (18'd0 - {1'b0, qc}) : {1'b0, qc};
    end
  end

  logic        hit_r;
  logic [17:0] nx_r, ny_r, nz_r;
  logic [31:0] depth_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= fc.hit;
      if (!fc.hit) begin
        nx_r <= '0; ny_r <= '0; nz_r <= '0; depth_r <= '0;
      end else begin
        depth_r <= fc.depth;
        if (fc.dflt) begin
          nx_r <= '0;
          ny_r <= {1'b0, SCT_ONE_Q16};
          nz_r <= '0;
        end else begin
          nx_r <= nrm[0];
          ny_r <= nrm[1];
          nz_r <= nrm[2];
        end
      end
    end
  end

  assign hit      = hit_r;
  assign normal_x = nx_r;
  assign normal_y = ny_r;
  assign normal_z = nz_r;
  assign depth    = depth_r;

endmodule

[rtl/sphere_contact_test.sv]
`timescale 1ns / 1ps
// Sphere-sphere and box-sphere contact test, Q16.16 fixed point. A new pair is
// accepted every cycle while nothing stalls; each result passes through the
// 32-stage square root and 17-stage normal dividers. A 4-deep queue separates
// the classify front end from the arithmetic.
// Depends on sct_pkg, sct_front, sct_fifo, sct_back.
module sphere_contact_test import sct_pkg::*; #(
  parameter int unsigned QDEPTH = SCT_QDEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [351:0] in_tdata,   // ax, ay, az, bx, by_max, bz, cx, cy, cz, radius_a, radius_c
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // normal_x, normal_y, normal_z, depth
  output logic         out_tuser,  // hit
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0] eps_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == SCT_REG_EPS) ? {16'd0, eps_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= SCT_EPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == SCT_REG_EPS) begin
      eps_r <= cfg_pwdata[15:0];
    end
  end

  logic      f_valid, f_ready, q_valid, q_ready;
  sct_item_t f_item, q_item;
  logic [17:0] nx, ny, nz;
  logic [31:0] dep;

  sct_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mode       (in_tuser),
    .a_pos      (in_tdata[95:0]),
    .b_pos      (in_tdata[191:96]),
    .c_pos      (in_tdata[287:192]),
    .radius_a   (in_tdata[318:288]),
    .radius_c   (in_tdata[349:319]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  sct_fifo #(.QDEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  sct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eps        (eps_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hit        (out_tuser),
    .normal_x   (nx),
    .normal_y   (ny),
    .normal_z   (nz),
    .depth      (dep)
  );

  assign out_tdata = {2'b00, dep, nz, ny, nx};

endmodule
